// File: src/sliding_window_rms_phasor_assert.svh
// assertion macros for the rms and phasor block
`ifndef SLIDING_WINDOW_RMS_PHASOR_ASSERT_SVH
`define SLIDING_WINDOW_RMS_PHASOR_ASSERT_SVH

// antecedent in this cycle implies consequent in the next cycle
`define SWRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define SWRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

// File: src/swrp_pkg.sv
// package with sizes and the sine table for the rms and phasor block
package swrp_pkg;
	localparam int WINDOW = 16;
	localparam int WIN_LOG = $clog2(WINDOW);
	localparam int CODE_W = 10;
	localparam int HARM_W = 3;
	localparam int TRIG_W = 16;
	localparam int OP_W = 2 * CODE_W + 1;
	localparam int PROD_W = 2 * OP_W;
	localparam int VSQ_W = 2 * CODE_W + WIN_LOG;
	localparam int PSQ_W = 4 * CODE_W + WIN_LOG;
	localparam int ACC_W = CODE_W + 14 + WIN_LOG + 2;
	localparam int RMS_SH = 12 - WIN_LOG;
	localparam int SQ_W = PSQ_W + RMS_SH;
	localparam int ROOT_W = SQ_W / 2;
	localparam int RT_W = $clog2(ROOT_W + 2);
	localparam int PH_SH = WIN_LOG + 7;
	localparam int RMS_W = 16;
	localparam int PRMS_W = 26;
	localparam int PHASOR_W = 18;

	typedef logic signed [TRIG_W-1:0] trig_tab_t [WINDOW];

	function automatic logic [63:0] quarter_sin(input logic [63:0] x);
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] r;
		t = x << 2;
		t2 = (t * t) >> 16;
		r = 64'd172272;
		r = 64'd5026993 - ((r * t2) >> 16);
		r = 64'd85569306 - ((r * t2) >> 16);
		r = 64'd693598668 - ((r * t2) >> 16);
		r = 64'd1686629713 - ((r * t2) >> 16);
		return (r * t + (64'd1 << 31)) >> 32;
	endfunction

	function automatic trig_tab_t calc_sin_tab();
		trig_tab_t tab;
		logic [63:0] ph;
		logic [63:0] f;
		logic [63:0] s;
		for (int m = 0; m < WINDOW; m++) begin
			ph = ((64'(m) * 64'd65536) + 64'(WINDOW / 2)) / 64'(WINDOW);
			ph = ph & 64'hFFFF;
			f = ph & 64'd16383;
			s = ph[14] ? quarter_sin(64'd16384 - f) : quarter_sin(f);
			tab[m] = ph[15] ? -TRIG_W'(s) : TRIG_W'(s);
		end
		return tab;
	endfunction

	localparam trig_tab_t SIN_TAB = calc_sin_tab();

	typedef enum logic [2:0] {
		OP_VV = 3'd0,
		OP_CC = 3'd1,
		OP_VC = 3'd2,
		OP_PP = 3'd3,
		OP_VCOS = 3'd4,
		OP_VSIN = 3'd5
	} mac_op_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MAC = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_ROOT = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;
endpackage

// File: src/sliding_window_rms_phasor.sv
// top level of the sliding window rms and dft phasor block
// usage:
// - input channel: voltage_code and current_code with in_valid; the block
//   raises in_stall while it works on a word, so one word is taken at a time
// - output channel: five result fields with out_valid; the receiver holds
//   out_stall high to keep the word, which stays unchanged meanwhile
// - config channel: cfg_data with cfg_valid, cfg_ready always high; sets
//   the harmonic order (reset value 1); write only while idle
// latency: 6 cycles per window entry on the shared multiplier (96), one
//   drain cycle, then three square roots of 28 cycles each on the shared
//   root unit (84), then one cycle to the output register: 182 cycles
// throughput: one word per 183 cycles (one idle cycle before the next
//   accept), set by the single multiplier and the single bit-serial root unit
// a new word can be taken while the previous result waits in the output
//   register; the block then holds before its final step until it is free
// reset: windows cleared to zero, harmonic set to 1, no output pending
module sliding_window_rms_phasor (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [swrp_pkg::CODE_W-1:0]            voltage_code,
	input  logic [swrp_pkg::CODE_W-1:0]            current_code,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [swrp_pkg::RMS_W-1:0]             voltage_rms,
	output logic [swrp_pkg::RMS_W-1:0]             current_rms,
	output logic [swrp_pkg::PRMS_W-1:0]            power_rms,
	output logic signed [swrp_pkg::PHASOR_W-1:0]   phasor_real,
	output logic signed [swrp_pkg::PHASOR_W-1:0]   phasor_imag,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [swrp_pkg::HARM_W-1:0]            cfg_data
);
	import swrp_pkg::*;

	state_t state_q;
	logic [CODE_W-1:0] vwin_q [WINDOW];
	logic [CODE_W-1:0] cwin_q [WINDOW];
	logic [HARM_W-1:0] harm_q;
	logic [WIN_LOG-1:0] k_q;
	mac_op_t step_q;
	mac_op_t op_s1;
	logic acc_en_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic [VSQ_W-1:0] vsq_q;
	logic [VSQ_W-1:0] isq_q;
	logic [PSQ_W-1:0] psq_q;
	logic signed [ACC_W-1:0] re_q;
	logic signed [ACC_W-1:0] im_q;
	logic [1:0] sel_q;
	logic [RT_W-1:0] rt_q;
	logic [SQ_W-1:0] x_q;
	logic [SQ_W-1:0] res_q;
	logic [SQ_W-1:0] bit_q;
	logic [ROOT_W-1:0] vroot_q;
	logic [ROOT_W-1:0] iroot_q;
	logic out_valid_q;

	logic [WIN_LOG-1:0] m_idx;
	logic [WIN_LOG-1:0] c_idx;
	logic signed [OP_W-1:0] op_a;
	logic signed [OP_W-1:0] op_b;
	logic signed [OP_W-1:0] v_op;
	logic signed [OP_W-1:0] c_op;
	logic [SQ_W-1:0] trial;
	logic [SQ_W-1:0] sq_in;
	logic signed [ACC_W-1:0] re_rnd;
	logic signed [ACC_W-1:0] im_rnd;
	logic signed [ACC_W-1:0] re_sh;
	logic signed [ACC_W-1:0] im_sh;
	logic signed [PHASOR_W-1:0] re_sat;
	logic signed [PHASOR_W-1:0] im_sat;
	logic accept;
	logic out_take;
	logic out_free;

	assign accept = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_take = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign m_idx = WIN_LOG'(harm_q * k_q);
	assign c_idx = m_idx + WIN_LOG'(WINDOW / 4);
	assign v_op = OP_W'(vwin_q[0]);
	assign c_op = OP_W'(cwin_q[0]);

	always_comb begin
		op_a = v_op;
		op_b = v_op;
		case (step_q)
			OP_VV: begin
				op_a = v_op;
				op_b = v_op;
			end
			OP_CC: begin
				op_a = c_op;
				op_b = c_op;
			end
			OP_VC: begin
				op_a = v_op;
				op_b = c_op;
			end
			OP_PP: begin
				op_a = OP_W'(prod_s1);
				op_b = OP_W'(prod_s1);
			end
			OP_VCOS: begin
				op_a = v_op;
				op_b = OP_W'(SIN_TAB[c_idx]);
			end
			OP_VSIN: begin
				op_a = v_op;
				op_b = OP_W'(SIN_TAB[m_idx]);
			end
			default: begin
				op_a = v_op;
				op_b = v_op;
			end
		endcase
	end

	always_comb begin
		case (sel_q)
			2'd0: sq_in = SQ_W'(vsq_q) << RMS_SH;
			2'd1: sq_in = SQ_W'(isq_q) << RMS_SH;
			default: sq_in = SQ_W'(psq_q) << RMS_SH;
		endcase
	end

	assign trial = res_q + bit_q;

	always_comb begin
		re_rnd = re_q + ACC_W'(WINDOW * 64);
		im_rnd = im_q + ACC_W'(WINDOW * 64);
		re_sh = re_rnd >>> PH_SH;
		im_sh = im_rnd >>> PH_SH;
		if (re_sh > ACC_W'(131071))
			re_sat = PHASOR_W'(131071);
		else if (re_sh < -ACC_W'(131072))
			re_sat = PHASOR_W'(-131072);
		else
			re_sat = PHASOR_W'(re_sh);
		if (im_sh > ACC_W'(131071))
			im_sat = PHASOR_W'(131071);
		else if (im_sh < -ACC_W'(131072))
			im_sat = PHASOR_W'(-131072);
		else
			im_sat = PHASOR_W'(im_sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			harm_q <= HARM_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			harm_q <= cfg_data;
		end
	end

	// windows: shift in on accept, rotate once per entry while walking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				vwin_q[i] <= '0;
				cwin_q[i] <= '0;
			end
		end else if (accept) begin
			for (int i = 0; i < WINDOW - 1; i++) begin
				vwin_q[i] <= vwin_q[i+1];
				cwin_q[i] <= cwin_q[i+1];
			end
			vwin_q[WINDOW-1] <= voltage_code;
			cwin_q[WINDOW-1] <= current_code;
		end else if (state_q == ST_MAC && step_q == OP_VSIN) begin
			for (int i = 0; i < WINDOW - 1; i++) begin
				vwin_q[i] <= vwin_q[i+1];
				cwin_q[i] <= cwin_q[i+1];
			end
			vwin_q[WINDOW-1] <= vwin_q[0];
			cwin_q[WINDOW-1] <= cwin_q[0];
		end
	end

	// shared multiplier, product registered before accumulation
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		op_s1 <= step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
		end else begin
			acc_en_s1 <= (state_q == ST_MAC);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vsq_q <= '0;
			isq_q <= '0;
			psq_q <= '0;
			re_q <= '0;
			im_q <= '0;
		end else if (acc_en_s1) begin
			case (op_s1)
				OP_VV: vsq_q <= vsq_q + VSQ_W'(prod_s1);
				OP_CC: isq_q <= isq_q + VSQ_W'(prod_s1);
				OP_PP: psq_q <= psq_q + PSQ_W'(prod_s1);
				OP_VCOS: re_q <= re_q + ACC_W'(prod_s1);
				OP_VSIN: im_q <= im_q - ACC_W'(prod_s1);
				default: ;
			endcase
		end
	end

	// bit-serial square root, shared by the three rms values
	always_ff @(posedge clk) begin
		if (state_q == ST_ROOT) begin
			if (rt_q == '0) begin
				x_q <= sq_in;
				res_q <= '0;
				bit_q <= SQ_W'(1) << (SQ_W - 2);
			end else if (rt_q <= RT_W'(ROOT_W)) begin
				if (x_q >= trial) begin
					x_q <= x_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else if (sel_q == 2'd0) begin
				vroot_q <= ROOT_W'(res_q);
			end else if (sel_q == 2'd1) begin
				iroot_q <= ROOT_W'(res_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			step_q <= OP_VV;
			sel_q <= '0;
			rt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MAC;
						k_q <= '0;
						step_q <= OP_VV;
					end
				end
				ST_MAC: begin
					case (step_q)
						OP_VV: step_q <= OP_CC;
						OP_CC: step_q <= OP_VC;
						OP_VC: step_q <= OP_PP;
						OP_PP: step_q <= OP_VCOS;
						OP_VCOS: step_q <= OP_VSIN;
						default: begin
							step_q <= OP_VV;
							k_q <= k_q + 1'b1;
							if (k_q == WIN_LOG'(WINDOW - 1))
								state_q <= ST_DRAIN;
						end
					endcase
				end
				ST_DRAIN: begin
					state_q <= ST_ROOT;
					sel_q <= '0;
					rt_q <= '0;
				end
				ST_ROOT: begin
					if (rt_q == RT_W'(ROOT_W + 1)) begin
						rt_q <= '0;
						if (sel_q == 2'd2)
							state_q <= ST_DONE;
						else
							sel_q <= sel_q + 1'b1;
					end else begin
						rt_q <= rt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			voltage_rms <= (vroot_q > ROOT_W'(65535)) ? RMS_W'(65535) : RMS_W'(vroot_q);
			current_rms <= (iroot_q > ROOT_W'(65535)) ? RMS_W'(65535) : RMS_W'(iroot_q);
			power_rms <= PRMS_W'(res_q);
			phasor_real <= re_sat;
			phasor_imag <= im_sat;
		end
	end
endmodule

// File: src/swrp_checker.sv
// port checker for the rms and phasor block, bound to the top level
`include "sliding_window_rms_phasor_assert.svh"

module swrp_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_stall,
	input logic                                   out_valid,
	input logic                                   out_stall,
	input logic [swrp_pkg::RMS_W-1:0]             voltage_rms,
	input logic [swrp_pkg::RMS_W-1:0]             current_rms,
	input logic [swrp_pkg::PRMS_W-1:0]            power_rms,
	input logic signed [swrp_pkg::PHASOR_W-1:0]   phasor_real,
	input logic signed [swrp_pkg::PHASOR_W-1:0]   phasor_imag,
	input logic                                   cfg_valid,
	input logic                                   cfg_ready
);
	import swrp_pkg::*;

	logic [2*RMS_W+PRMS_W+2*PHASOR_W-1:0] out_word;

	assign out_word = {voltage_rms, current_rms, power_rms, phasor_real, phasor_imag};

	`SWRP_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	`SWRP_ASSERT_NOW(a_result_after_work, clk, arst_n, $rose(out_valid), $past(in_stall))
	`SWRP_ASSERT_NEXT(a_out_held, clk, arst_n, out_valid && out_stall, out_valid)
	`SWRP_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(out_word))
	`SWRP_ASSERT_NOW(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)
endmodule

bind sliding_window_rms_phasor swrp_checker u_swrp_checker (.*);
